// ----- rtl/h263cq_pkg.sv -----
package h263cq_pkg;

	localparam int CoeffW    = 16;
	localparam int IndexW    = 6;
	localparam int QpW       = 5;
	localparam int LevelW    = 12;
	localparam int ReconW    = 16;
	localparam int MaxDcW    = 12;
	localparam int PixBitsW  = 4;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 12;

	localparam int InDataW   = 32;
	localparam int InUserW   = 2;
	localparam int OutDataW  = 32;

	localparam int NumW      = 16;
	localparam int DivisorW  = 6;
	localparam int QuotW     = 15;
	localparam int RecipShift = 22;
	localparam int RecipW    = 22;
	localparam int RecipDepth = 64;
	localparam int MagProdW  = 17;

	localparam logic [MaxDcW-1:0]   MaxDcRst       = 12'd255;
	localparam logic [PixBitsW-1:0] PixelBitsRst   = 4'd8;
	localparam logic                ShortHeaderRst = 1'b0;

	localparam logic [LevelW-1:0]   LevelPosMax    = 12'd2047;
	localparam logic [LevelW-1:0]   LevelNegMax    = 12'd2048;
	localparam logic [DivisorW-1:0] ShortDcScaler  = 6'd8;
	localparam logic [PixBitsW-1:0] PixBitsFull    = 4'd12;
	localparam logic [4:0]          SatShift       = 5'd3;
	localparam logic [MagProdW-1:0] ReconMagMax    = 17'd32768;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_MAX_DC       = 2'd0,
		CFG_PIXEL_BITS   = 2'd1,
		CFG_SHORT_HEADER = 2'd2
	} cfg_idx_t;

	function automatic logic [DivisorW-1:0] dc_scale_sel(input logic [QpW-1:0] q,
			input logic chroma);
		logic [DivisorW-1:0] q6;
		logic [DivisorW-1:0] s;
		q6 = {1'b0, q};
		priority if (q6 <= 6'd4) begin
			s = 6'd8;
		end else if (!chroma && q6 <= 6'd8) begin
			s = q6 << 1;
		end else if (!chroma && q6 <= 6'd24) begin
			s = q6 + 6'd8;
		end else if (!chroma) begin
			s = (q6 << 1) - 6'd16;
		end else if (q6 <= 6'd24) begin
			s = (q6 + 6'd13) >> 1;
		end else begin
			s = q6 - 6'd6;
		end
		return s;
	endfunction

endpackage

// ----- rtl/h263_coeff_quant_dequant.sv -----
// Channel   Direction  Handshake                      Word
// s_axis    in         s_axis_tvalid/s_axis_tready     coefficient, index, qp; tuser intra, chroma
// m_axis    out        m_axis_tvalid/m_axis_tready     quant_level, recon_coeff
// cfg       in         cfg_valid/cfg_ready             register index and write data
//
// One word is accepted per cycle unless the output stalls; each word passes through every stage.
// Stages: operand selection and reciprocal lookup, reciprocal multiply, back multiply,
// correction, level clamping, dequantizer multiply and output saturation.
// Each stage holds its word while the next one is full and stalled, so bubbles collapse.
// Reset clears the stage valid bits and loads the register defaults; cfg_ready is always high.
module h263_coeff_quant_dequant
	import h263cq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// [15:0] coefficient, [21:16] coeff_index, [26:22] qp, [31:27] zero
	input  logic [InDataW-1:0]  s_axis_tdata,
	// [0] intra, [1] chroma
	input  logic [InUserW-1:0]  s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// [11:0] quant_level, [27:12] recon_coeff, [31:28] zero
	output logic [OutDataW-1:0] m_axis_tdata,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic [MaxDcW-1:0]   max_dc_q;
	logic [PixBitsW-1:0] pixel_bits_q;
	logic                short_header_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dc_q       <= MaxDcRst;
			pixel_bits_q   <= PixelBitsRst;
			short_header_q <= ShortHeaderRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MAX_DC:       max_dc_q       <= cfg_data[MaxDcW-1:0];
				CFG_PIXEL_BITS:   pixel_bits_q   <= cfg_data[PixBitsW-1:0];
				CFG_SHORT_HEADER: short_header_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [RecipW-1:0] recip_tab [RecipDepth];

	for (genvar g = 0; g < RecipDepth; g++) begin : g_recip
		localparam logic [RecipW-1:0] Recip =
			RecipW'((64'd1 << RecipShift) / ((g < 2) ? 2 : g));
		assign recip_tab[g] = Recip;
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

	assign adv7 = !v_s7 || m_axis_tready;
	assign adv6 = !v_s6 || adv7;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_axis_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
			if (adv7) v_s7 <= v_s6;
		end
	end

	// Stage 1: magnitude, numerator and divisor selection.
	logic [CoeffW-1:0]   coef_in;
	logic [IndexW-1:0]   idx_in;
	logic [QpW-1:0]      qp_raw_in, qp_in;
	logic                dc_in, neg_in;
	logic [NumW-1:0]     mag_in, inter_n_in, dc_n_in, n_in;
	logic [DivisorW-1:0] scal_in, d_in;
	logic [NumW:0]       dc_sum_in;
	logic [NumW-1:0]     half_qp_in;

	always_comb begin
		coef_in    = s_axis_tdata[15:0];
		idx_in     = s_axis_tdata[21:16];
		qp_raw_in  = s_axis_tdata[26:22];
		qp_in      = (qp_raw_in == '0) ? QpW'(1) : qp_raw_in;
		dc_in      = s_axis_tuser[0] && (idx_in == '0);
		neg_in     = coef_in[CoeffW-1];
		mag_in     = neg_in ? (~coef_in + NumW'(1)) : coef_in;
		scal_in    = dc_scale_sel(qp_in, s_axis_tuser[1]);
		dc_sum_in  = {coef_in[CoeffW-1], coef_in} + (NumW+1)'(scal_in >> 1);
		dc_n_in    = (dc_sum_in[NumW] || dc_sum_in == '0) ? '0 : dc_sum_in[NumW-1:0];
		half_qp_in = NumW'(qp_in >> 1);
		inter_n_in = (mag_in < half_qp_in) ? '0 : (mag_in - half_qp_in);
		priority if (dc_in) begin
			n_in = dc_n_in;
		end else if (s_axis_tuser[0]) begin
			n_in = mag_in;
		end else begin
			n_in = inter_n_in;
		end
		d_in = dc_in ? scal_in : {qp_in, 1'b0};
	end

	logic [NumW-1:0]     n_s1, n_s2, n_s3;
	logic [DivisorW-1:0] d_s1, d_s2, d_s3;
	logic [RecipW-1:0]   recip_s1;
	logic                neg_s1, neg_s2, neg_s3, neg_s4;
	logic                dc_s1, dc_s2, dc_s3, dc_s4, dc_s5;
	logic [QpW-1:0]      qp_s1, qp_s2, qp_s3, qp_s4, qp_s5;
	logic [DivisorW-1:0] scal_s1, scal_s2, scal_s3, scal_s4, scal_s5;
	logic [QuotW-1:0]    q0_s2, q0_s3, q_s4;
	logic [NumW-1:0]     prod_s3;
	logic [LevelW-1:0]   level_s5, mag_s5, level_s6, level_s7;
	logic                sign_s5, zero_s5, sign_s6, zero_s6, dec_s6;
	logic [MagProdW-1:0] p_s6;
	logic [ReconW-1:0]   recon_s7;

	// Stage 2: multiply by the reciprocal; the estimate is exact or one low.
	logic [NumW+RecipW-1:0] recip_prod;
	assign recip_prod = (NumW+RecipW)'(n_s1) * (NumW+RecipW)'(recip_s1);

	// Stage 3: multiply back by the divisor.
	logic [NumW-1:0] back_prod;
	assign back_prod = NumW'(q0_s2) * NumW'(d_s2);

	// Stage 4: one correction step.
	logic [NumW-1:0] rem_s3;
	assign rem_s3 = n_s3 - prod_s3;

	// Stage 5: level clamping and sign.
	logic [LevelW-1:0] dc_cap, dc_u, dc_lvl, ac_mag, mag_c, level_c;
	always_comb begin
		dc_cap = max_dc_q - MaxDcW'(1);
		dc_u   = ({3'b0, dc_cap} < q_s4) ? dc_cap : q_s4[LevelW-1:0];
		priority if (max_dc_q <= MaxDcW'(1) || dc_u == '0) begin
			dc_lvl = LevelW'(1);
		end else if (dc_u > LevelPosMax) begin
			dc_lvl = LevelPosMax;
		end else begin
			dc_lvl = dc_u;
		end
		priority if (neg_s4 && q_s4 > {3'b0, LevelNegMax}) begin
			ac_mag = LevelNegMax;
		end else if (!neg_s4 && q_s4 > {3'b0, LevelPosMax}) begin
			ac_mag = LevelPosMax;
		end else begin
			ac_mag = q_s4[LevelW-1:0];
		end
		mag_c   = dc_s4 ? dc_lvl : ac_mag;
		level_c = (!dc_s4 && neg_s4) ? (~ac_mag + LevelW'(1)) : mag_c;
	end

	// Stage 6: dequantizer multiply.
	logic [DivisorW-1:0]   mul_a;
	logic [LevelW:0]       mul_b;
	logic [MagProdW-1:0]   deq_prod;
	always_comb begin
		mul_a    = dc_s5 ? (short_header_q ? ShortDcScaler : scal_s5) : {1'b0, qp_s5};
		mul_b    = dc_s5 ? {1'b0, mag_s5} : {mag_s5, 1'b1};
		deq_prod = MagProdW'(mul_a) * MagProdW'(mul_b);
	end

	// Stage 7: saturation to the pixel-depth limit.
	logic [MagProdW-1:0] lim, v_mag, r_mag;
	logic [4:0]          lim_shift;
	always_comb begin
		lim_shift = {1'b0, pixel_bits_q} + SatShift;
		lim   = (pixel_bits_q >= PixBitsFull) ? ReconMagMax : (MagProdW'(1) << lim_shift);
		v_mag = zero_s6 ? '0 : (p_s6 - MagProdW'(dec_s6));
		priority if (sign_s6 && v_mag > lim) begin
			r_mag = lim;
		end else if (!sign_s6 && v_mag > lim - MagProdW'(1)) begin
			r_mag = lim - MagProdW'(1);
		end else begin
			r_mag = v_mag;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			n_s1     <= n_in;
			d_s1     <= d_in;
			recip_s1 <= recip_tab[d_in];
			neg_s1   <= neg_in;
			dc_s1    <= dc_in;
			qp_s1    <= qp_in;
			scal_s1  <= scal_in;
		end
		if (adv2) begin
			q0_s2   <= recip_prod[RecipShift +: QuotW];
			n_s2    <= n_s1;
			d_s2    <= d_s1;
			neg_s2  <= neg_s1;
			dc_s2   <= dc_s1;
			qp_s2   <= qp_s1;
			scal_s2 <= scal_s1;
		end
		if (adv3) begin
			prod_s3 <= back_prod;
			q0_s3   <= q0_s2;
			n_s3    <= n_s2;
			d_s3    <= d_s2;
			neg_s3  <= neg_s2;
			dc_s3   <= dc_s2;
			qp_s3   <= qp_s2;
			scal_s3 <= scal_s2;
		end
		if (adv4) begin
			q_s4    <= (rem_s3 >= NumW'(d_s3)) ? (q0_s3 + QuotW'(1)) : q0_s3;
			neg_s4  <= neg_s3;
			dc_s4   <= dc_s3;
			qp_s4   <= qp_s3;
			scal_s4 <= scal_s3;
		end
		if (adv5) begin
			level_s5 <= level_c;
			mag_s5   <= mag_c;
			sign_s5  <= !dc_s4 && neg_s4;
			zero_s5  <= (mag_c == '0);
			dc_s5    <= dc_s4;
			qp_s5    <= qp_s4;
			scal_s5  <= scal_s4;
		end
		if (adv6) begin
			p_s6     <= deq_prod;
			dec_s6   <= !dc_s5 && !qp_s5[0];
			sign_s6  <= sign_s5;
			zero_s6  <= zero_s5;
			level_s6 <= level_s5;
		end
		if (adv7) begin
			level_s7 <= level_s6;
			recon_s7 <= sign_s6 ? ReconW'(~r_mag + MagProdW'(1)) : r_mag[ReconW-1:0];
		end
	end

	assign m_axis_tvalid = v_s7;
	assign m_axis_tdata  = {(OutDataW-LevelW-ReconW)'(0), recon_s7, level_s7};

endmodule

// ----- rtl/h263cq_checker.sv -----
module h263cq_checker
	import h263cq_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tvalid,
	input logic                s_axis_tready,
	input logic [InDataW-1:0]  s_axis_tdata,
	input logic [InUserW-1:0]  s_axis_tuser,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [OutDataW-1:0] m_axis_tdata,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic [CfgIdxW-1:0]  cfg_index,
	input logic [CfgDataW-1:0] cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked while output is empty");

	a_zero_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[11:0] == 12'd0) == (m_axis_tdata[27:12] == 16'd0)))
		else $error("zero level and zero reconstruction disagree");

	a_sign_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[11] == m_axis_tdata[27]))
		else $error("level and reconstruction signs disagree");

endmodule

bind h263_coeff_quant_dequant h263cq_checker u_checker (.*);
